// ===== rtl/triangle_face_cull_top_defines.svh =====
// assertion macros shared by the checker of the triangle face cull block
`ifndef TRIANGLE_FACE_CULL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_CULL_TOP_DEFINES_SVH

// condition seen at one edge implies a consequence at the next edge
`define TFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfc checker: next-cycle rule broken");

// condition implies a consequence at the same edge
`define TFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfc checker: same-cycle rule broken");

`endif

// ===== rtl/tfc_pkg.sv =====
// shared types and constants of the triangle face cull block
package tfc_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int TAG_WIDTH_DEFAULT   = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int TRI_VERTS  = 3;
    localparam int CFG_DATA_W = 3;
    localparam int CFG_IDX_W  = 2;

    // index of the last vertex of a triangle, also the gather count at which a triangle completes
    localparam logic [1:0] LAST_IDX = 2'(TRI_VERTS - 1);

    // primitive kinds at or above this value are triangles
    localparam logic [2:0] KIND_TRI_FIRST = 3'd4;

    localparam logic [1:0] CULL_BACK  = 2'd0;
    localparam logic [1:0] CULL_FRONT = 2'd1;

    localparam logic [2:0] KIND_RESET    = 3'd4;
    localparam logic       WINDING_RESET = 1'b1;
    localparam logic [1:0] CULL_RESET    = 2'd0;
    localparam logic       ENABLE_RESET  = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIMITIVE_KIND = 2'd0,
        REG_WINDING_CCW    = 2'd1,
        REG_CULL_MODE      = 2'd2,
        REG_CULL_ENABLE    = 2'd3
    } tfc_reg_idx_t;

    typedef struct packed {
        logic [2:0] primitive_kind;
        logic       winding_ccw;
        logic [1:0] cull_mode;
        logic       cull_enable;
    } tfc_cfg_t;

    // per-record control carried through the queue
    typedef struct packed {
        logic is_tri;
        logic front;
    } tfc_ctrl_t;

    localparam int CTRL_W = $bits(tfc_ctrl_t);

endpackage

// ===== rtl/triangle_face_cull_top.sv =====
// top level of the triangle face cull block: config registers and the three units
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  vertex   | push / full        | pos_x, pos_y, vertex_tag
//  result   | empty / pop        | out_x, out_y, out_tag, out_front, out_last
//  config   | cfg_we             | cfg_index, cfg_data
//
//  one vertex in per cycle while full is low; a kept triangle leaves as three results, one per vertex
//  a result follows the vertex that completes it through the difference stage,
//  product stage, queue write and output record load
//  full rises when queue plus pipeline hold QUEUE_DEPTH records; then no vertex is taken
//  reset: triangles, ccw front, cull back, culling off; gather count, pipe and queue empty
module triangle_face_cull_top #(
    parameter int COORD_WIDTH = tfc_pkg::COORD_WIDTH_DEFAULT,
    parameter int TAG_WIDTH   = tfc_pkg::TAG_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = tfc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // vertex input
    input  logic                              push,
    output logic                              full,
    input  logic signed [COORD_WIDTH-1:0]     pos_x,
    input  logic signed [COORD_WIDTH-1:0]     pos_y,
    input  logic [TAG_WIDTH-1:0]              vertex_tag,
    // vertex output
    output logic                              empty,
    input  logic                              pop,
    output logic signed [COORD_WIDTH-1:0]     out_x,
    output logic signed [COORD_WIDTH-1:0]     out_y,
    output logic [TAG_WIDTH-1:0]              out_tag,
    output logic                              out_front,
    output logic                              out_last
);

    localparam int VW    = 2 * COORD_WIDTH + TAG_WIDTH;
    localparam int REC_W = tfc_pkg::CTRL_W + tfc_pkg::TRI_VERTS * VW;
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);

    tfc_pkg::tfc_cfg_t cfg_reg;
    tfc_pkg::tfc_cfg_t cfg_next;

    logic              q_push;
    logic [REC_W-1:0]  q_wr_data;
    logic              q_pop;
    logic [REC_W-1:0]  q_rd_data;
    logic              q_empty;
    logic [CNTW-1:0]   q_count;

    // register writes keep only the low bits each register holds
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tfc_pkg::REG_PRIMITIVE_KIND: cfg_next.primitive_kind = cfg_data[2:0];
                tfc_pkg::REG_WINDING_CCW:    cfg_next.winding_ccw    = cfg_data[0];
                tfc_pkg::REG_CULL_MODE:      cfg_next.cull_mode      = cfg_data[1:0];
                tfc_pkg::REG_CULL_ENABLE:    cfg_next.cull_enable    = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primitive_kind <= tfc_pkg::KIND_RESET;
            cfg_reg.winding_ccw    <= tfc_pkg::WINDING_RESET;
            cfg_reg.cull_mode      <= tfc_pkg::CULL_RESET;
            cfg_reg.cull_enable    <= tfc_pkg::ENABLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: gather, area sign, keep or drop
    tfc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vertex_tag (vertex_tag),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    // records waiting for the back end
    tfc_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .count   (q_count)
    );

    // back: one vertex per result transfer
    tfc_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_tag   (out_tag),
        .out_front (out_front),
        .out_last  (out_last)
    );

endmodule

// ===== rtl/tfc_front.sv =====
// front end: vertex gather, signed area pipeline and cull decision
module tfc_front #(
    parameter int COORD_WIDTH = tfc_pkg::COORD_WIDTH_DEFAULT,
    parameter int TAG_WIDTH   = tfc_pkg::TAG_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = tfc_pkg::QUEUE_DEPTH_DEFAULT,
    localparam int VW    = 2 * COORD_WIDTH + TAG_WIDTH,
    localparam int REC_W = tfc_pkg::CTRL_W + tfc_pkg::TRI_VERTS * VW,
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tfc_pkg::tfc_cfg_t             cfg,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic [TAG_WIDTH-1:0]          vertex_tag,
    input  logic [CNTW-1:0]               q_count,
    output logic                          q_push,
    output logic [REC_W-1:0]              q_data
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;

    logic                 accept;
    logic                 tri_kind;
    logic                 launch;
    logic [VW-1:0]        in_vert;
    logic [CNTW:0]        occupancy;

    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic [VW-1:0]        held0_reg;
    logic [VW-1:0]        held1_reg;

    logic signed [COORD_WIDTH-1:0] x0;
    logic signed [COORD_WIDTH-1:0] y0;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_tri_reg;
    logic [3*VW-1:0]      s1_verts_reg;
    logic signed [DW-1:0] s1_dx1_reg;
    logic signed [DW-1:0] s1_dy2_reg;
    logic signed [DW-1:0] s1_dx2_reg;
    logic signed [DW-1:0] s1_dy1_reg;

    logic                 s2_valid_reg;
    logic                 s2_tri_reg;
    logic [3*VW-1:0]      s2_verts_reg;
    logic signed [PW-1:0] s2_p1_reg;
    logic signed [PW-1:0] s2_p2_reg;

    logic signed [AW-1:0] area;
    logic                 area_pos;
    logic                 area_neg;
    logic                 is_front;
    logic                 keep;
    tfc_pkg::tfc_ctrl_t   ctrl;

    // credit check: queue entries plus records still in the pipeline
    assign occupancy = (CNTW+1)'(q_count) + (CNTW+1)'(s1_valid_reg)
                     + (CNTW+1)'(s2_valid_reg);
    assign full      = occupancy >= (CNTW+1)'(QUEUE_DEPTH);
    assign accept    = push && !full;

    assign tri_kind  = cfg.primitive_kind >= tfc_pkg::KIND_TRI_FIRST;
    assign launch    = accept && (!tri_kind || (cnt_reg == tfc_pkg::LAST_IDX));
    assign in_vert   = {pos_x, pos_y, vertex_tag};

    assign x0 = $signed(held0_reg[VW-1 -: COORD_WIDTH]);
    assign y0 = $signed(held0_reg[VW-COORD_WIDTH-1 -: COORD_WIDTH]);
    assign x1 = $signed(held1_reg[VW-1 -: COORD_WIDTH]);
    assign y1 = $signed(held1_reg[VW-COORD_WIDTH-1 -: COORD_WIDTH]);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && tri_kind)
        begin
            if (cnt_reg == tfc_pkg::LAST_IDX)
                cnt_next = 2'd0;
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    assign s1_valid_next = launch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= 2'd0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // gather storage and pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept && tri_kind && (cnt_reg == 2'd0))
            held0_reg <= in_vert;
        if (accept && tri_kind && (cnt_reg == 2'd1))
            held1_reg <= in_vert;
        if (launch)
        begin
            s1_tri_reg   <= tri_kind;
            s1_verts_reg <= {in_vert, held1_reg, held0_reg};
            s1_dx1_reg   <= DW'(x1) - DW'(x0);
            s1_dy2_reg   <= DW'(pos_y) - DW'(y0);
            s1_dx2_reg   <= DW'(pos_x) - DW'(x0);
            s1_dy1_reg   <= DW'(y1) - DW'(y0);
        end
        if (s1_valid_reg)
        begin
            s2_tri_reg   <= s1_tri_reg;
            s2_verts_reg <= s1_verts_reg;
            s2_p1_reg    <= PW'(s1_dx1_reg) * PW'(s1_dy2_reg);
            s2_p2_reg    <= PW'(s1_dx2_reg) * PW'(s1_dy1_reg);
        end
    end

    // zero area counts as back facing under either winding
    assign area     = AW'(s2_p1_reg) - AW'(s2_p2_reg);
    assign area_neg = area[AW-1];
    assign area_pos = !area[AW-1] && (area != '0);
    assign is_front = cfg.winding_ccw ? area_pos : area_neg;

    always_comb
    begin
        if (!cfg.cull_enable)
            keep = 1'b1;
        else
        begin
            case (cfg.cull_mode)
                tfc_pkg::CULL_BACK:  keep = is_front;
                tfc_pkg::CULL_FRONT: keep = !is_front;
                default:             keep = 1'b0;
            endcase
        end
    end

    assign ctrl.is_tri = s2_tri_reg;
    assign ctrl.front  = s2_tri_reg && is_front;
    assign q_push      = s2_valid_reg && (!s2_tri_reg || keep);
    assign q_data      = {ctrl, s2_verts_reg};

endmodule

// ===== rtl/tfc_queue.sv =====
// short record queue between front and back ends
module tfc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tfc_pkg::QUEUE_DEPTH_DEFAULT,
    localparam int PTRW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic [CNTW-1:0]  count
);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             do_rd;

    // writer never overruns: the front end holds credit for every slot
    assign do_rd   = rd_en && (count_reg != '0);
    assign empty   = count_reg == '0;
    assign count   = count_reg;
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !do_rd)
            count_next = count_reg + 1'b1;
        else if (!wr_en && do_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/tfc_back.sv =====
// back end: unrolls queued records into one vertex per transfer
module tfc_back #(
    parameter int COORD_WIDTH = tfc_pkg::COORD_WIDTH_DEFAULT,
    parameter int TAG_WIDTH   = tfc_pkg::TAG_WIDTH_DEFAULT,
    localparam int VW    = 2 * COORD_WIDTH + TAG_WIDTH,
    localparam int REC_W = tfc_pkg::CTRL_W + tfc_pkg::TRI_VERTS * VW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [REC_W-1:0]              q_data,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic [TAG_WIDTH-1:0]          out_tag,
    output logic                          out_front,
    output logic                          out_last
);

    tfc_pkg::tfc_ctrl_t q_ctrl;
    logic               rec_valid_reg;
    logic               rec_valid_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    tfc_pkg::tfc_ctrl_t rec_ctrl_reg;
    logic [3*VW-1:0]    rec_verts_reg;
    logic [VW-1:0]      slot;
    logic               xfer;
    logic               at_last;
    logic               load;

    assign q_ctrl  = tfc_pkg::tfc_ctrl_t'(q_data[REC_W-1 -: tfc_pkg::CTRL_W]);
    assign at_last = idx_reg == tfc_pkg::LAST_IDX;
    assign xfer    = pop && rec_valid_reg;
    assign load    = !q_empty && (!rec_valid_reg || (xfer && at_last));
    assign q_pop   = load;

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            rec_valid_next = 1'b1;
            // a pass-through record carries its vertex in the last slot
            idx_next       = q_ctrl.is_tri ? 2'd0 : tfc_pkg::LAST_IDX;
        end
        else if (xfer)
        begin
            if (at_last)
                rec_valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_ctrl_reg  <= q_ctrl;
            rec_verts_reg <= q_data[3*VW-1:0];
        end
    end

    assign slot      = rec_verts_reg[idx_reg*VW +: VW];
    assign empty     = !rec_valid_reg;
    assign out_x     = $signed(slot[VW-1 -: COORD_WIDTH]);
    assign out_y     = $signed(slot[VW-COORD_WIDTH-1 -: COORD_WIDTH]);
    assign out_tag   = slot[TAG_WIDTH-1:0];
    assign out_front = rec_ctrl_reg.front;
    assign out_last  = at_last;

endmodule

// ===== rtl/tfc_checker.sv =====
// port-level checker for the triangle face cull block, bound to the top level
`include "triangle_face_cull_top_defines.svh"

module tfc_checker #(
    parameter int COORD_WIDTH = tfc_pkg::COORD_WIDTH_DEFAULT,
    parameter int TAG_WIDTH   = tfc_pkg::TAG_WIDTH_DEFAULT
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic signed [COORD_WIDTH-1:0]     out_x,
    input logic signed [COORD_WIDTH-1:0]     out_y,
    input logic [TAG_WIDTH-1:0]              out_tag,
    input logic                              out_front,
    input logic                              out_last
);

    logic                                mid_xfer;
    logic [2*COORD_WIDTH+TAG_WIDTH+1:0]  result_bus;

    // transfer of a vertex that is not the end of its run
    assign mid_xfer   = !empty && pop && !out_last;
    assign result_bus = {out_x, out_y, out_tag, out_front, out_last};

    // a waiting result stays put until taken
    `TFC_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result_bus))

    // a triangle's next vertex is ready right after the previous one
    `TFC_ASSERT_NEXT(a_run_continues, mid_xfer, !empty)

    // the whole triangle carries one front flag
    `TFC_ASSERT_NEXT(a_run_same_front, mid_xfer, out_front == $past(out_front))

    // a run is never longer than three vertices
    `TFC_ASSERT_NOW(a_run_length, !empty && $past(mid_xfer) && $past(mid_xfer, 2), out_last)

endmodule

bind triangle_face_cull_top tfc_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .TAG_WIDTH   (TAG_WIDTH)
) u_tfc_checker (.*);
